[sv/wcts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts_pkg
// Shared constants, types and helpers for the wall column texture shader.
// ----------------------------------------------------------------------------
package wcts_pkg;

  // Texture geometry (powers of two)
  localparam int TEX_W        = 64;
  localparam int TEX_H        = 64;
  localparam int NUM_TEXTURES = 8;

  localparam int TX_W        = $clog2(TEX_W);
  localparam int TY_W        = $clog2(TEX_H);
  localparam int TEX_IDX_W   = (NUM_TEXTURES > 1) ? $clog2(NUM_TEXTURES) : 1;
  localparam int TEXEL_W     = TX_W + TY_W;
  localparam int TEX_SIZE    = TEX_W * TEX_H;
  localparam int STORE_DEPTH = NUM_TEXTURES * TEX_SIZE;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Widened load fields for range checks
  localparam int LADDR_X_W = 17;
  localparam int LTEX_X_W  = 5;

  // Texel row arithmetic: signed numerator and division remainder
  localparam int NUM_W = 18;
  localparam int REM_W = 17;

  // Pipeline depth ahead of the result queue, and queue size
  localparam int PIPE_DEPTH = TY_W + 3;
  localparam int FIFO_DEPTH = 2 ** $clog2(PIPE_DEPTH + 2);
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  HALF_MASK         = 8'h7F;
  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;
  localparam logic [3:0]  TEXTURE_COUNT_RST = 4'd8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_HEIGHT = 2'd0,
    CFG_TEXTURE_COUNT = 2'd1
  } wcts_cfg_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_SHADE = 1'b1
  } wcts_kind_e;

  typedef struct packed {
    logic                 kind;
    logic                 load_ok;
    logic [STORE_AW-1:0]  load_addr;
    logic [23:0]          colour;
    logic [10:0]          column;
    logic [9:0]           row;
    logic                 side;
    logic [TEX_IDX_W-1:0] tex;
    logic [TX_W-1:0]      tx;
  } meta_t;

  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [REM_W-1:0] rem;
    logic [TY_W-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [10:0] pixel_column;
    logic [9:0]  pixel_row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } result_t;

  function automatic logic [7:0] shade_channel(input logic [7:0] c, input logic side);
    shade_channel = side ? c : ((c >> 1) & HALF_MASK);
  endfunction

endpackage

[sv/wcts_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts interfaces
// Valid/ready channels: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface wcts_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  load_texture;
  logic [11:0] load_address;
  logic [23:0] load_colour;
  logic [10:0] column;
  logic [9:0]  row;
  logic [15:0] line_height;
  logic [7:0]  cell_value;
  logic [15:0] wall_fraction;
  logic        hit_side;
  logic        direction_negative;

  modport source (
    output valid, kind, load_texture, load_address, load_colour, column, row,
           line_height, cell_value, wall_fraction, hit_side, direction_negative,
    input  ready
  );
  modport sink (
    input  valid, kind, load_texture, load_address, load_colour, column, row,
           line_height, cell_value, wall_fraction, hit_side, direction_negative,
    output ready
  );
endinterface

interface wcts_result_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [10:0] pixel_column;
  logic [9:0]  pixel_row;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (
    output valid, pixel_valid, pixel_column, pixel_row, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, pixel_column, pixel_row, red, green, blue,
    output ready
  );
endinterface

interface wcts_cfg_if;
  import wcts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/wcts_row_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts_row_divider
// Pipelined texel row mapping: classify, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module wcts_row_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [wcts_pkg::NUM_W-1:0]   num_i,
  input  logic [15:0]                         lh_i,
  input  wcts_pkg::meta_t                     meta_i,
  output logic                                valid_o,
  output logic [wcts_pkg::TY_W-1:0]           ty_o,
  output wcts_pkg::meta_t                     meta_o
);
  import wcts_pkg::*;

  logic        valid_q [0:TY_W];
  div_t        div_q   [0:TY_W];
  logic [15:0] lh_q    [0:TY_W];
  meta_t       meta_q  [0:TY_W];

  // Stage 0: clamp cases. Below sat, numerator < 2*lh so quotient fits TY_W bits.
  div_t div0_d;
  always_comb begin
    div0_d.zero = num_i[NUM_W-1] || (num_i == '0);
    div0_d.sat  = num_i[REM_W-1:0] >= {lh_i, 1'b0};
    div0_d.rem  = num_i[REM_W-1:0];
    div0_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0]  <= div0_d;
    lh_q[0]   <= lh_i;
    meta_q[0] <= meta_i;
  end

  for (genvar i = 1; i <= TY_W; i++) begin : g_step
    logic [REM_W-1:0] rin;
    logic             take;
    div_t             div_d;

    always_comb begin
      if (i == 1) begin
        rin = div_q[i-1].rem;
      end else begin
        rin = {div_q[i-1].rem[REM_W-2:0], 1'b0};
      end
      take       = rin >= {1'b0, lh_q[i-1]};
      div_d      = div_q[i-1];
      div_d.rem  = take ? (rin - {1'b0, lh_q[i-1]}) : rin;
      div_d.quo  = {div_q[i-1].quo[TY_W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= valid_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[i]  <= div_d;
      lh_q[i]   <= lh_q[i-1];
      meta_q[i] <= meta_q[i-1];
    end
  end

  always_comb begin
    if (div_q[TY_W].zero) begin
      ty_o = '0;
    end else if (div_q[TY_W].sat) begin
      ty_o = '1;
    end else begin
      ty_o = div_q[TY_W].quo;
    end
  end

  assign valid_o = valid_q[TY_W];
  assign meta_o  = meta_q[TY_W];

endmodule

[sv/wcts_texture_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts_texture_ram
// Single-port texel store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module wcts_texture_ram (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          we_i,
  input  logic [wcts_pkg::STORE_AW-1:0] addr_i,
  input  logic [23:0]                   wdata_i,
  output logic [23:0]                   rdata_o
);
  import wcts_pkg::*;

  logic [23:0] mem_q [0:STORE_DEPTH-1];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/wcts_result_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts_result_fifo
// Result queue; sized to hold every item in flight so the pipe never stalls.
// ----------------------------------------------------------------------------
module wcts_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wcts_pkg::result_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output wcts_pkg::result_t data_o
);
  import wcts_pkg::*;

  result_t            fifo_q [0:FIFO_DEPTH-1];
  logic [FIFO_AW:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW:0]   rd_ptr_q, rd_ptr_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = (pop_i && valid_o) ? rd_ptr_q + 1'b1 : rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q[FIFO_AW-1:0]] <= data_i;
    end
  end

  assign valid_o = wr_ptr_q != rd_ptr_q;
  assign data_o  = fifo_q[rd_ptr_q[FIFO_AW-1:0]];

endmodule

[sv/wall_column_texture_shader_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_column_texture_shader_core
// Textures raycast wall pixels from a texel store, or loads texels into it.
// ----------------------------------------------------------------------------
// Usage:
//   item_i   - one beat per item: kind 0 writes load_colour into the texel
//              store, kind 1 shades one wall pixel of a screen column.
//   result_o - one beat per item, in order; loads return an all-zero beat.
//   cfg_i    - register writes (screen_height, texture_count), always ready;
//              write only while no item is outstanding.
// Timing:
//   One item per clock sustained while results are taken. A result reaches the
//   output queue through the input register, the clamp stage, one
//   texel-row quotient bit per stage (TY_W stages), and the store read.
//   The store is single ported; loads and reads take the same pipeline slot,
//   so a pixel always sees every earlier load.
// Stall: the output queue holds 16 beats; item_i.ready drops once 16 items
//   are outstanding and returns as results are taken.
// Reset: config returns to 480 rows and 8 textures, pipe and queue empty.
//   Texel store contents stay undefined until loaded; no clearing pass.
// ----------------------------------------------------------------------------
module wall_column_texture_shader_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  wcts_item_if.sink     item_i,
  wcts_result_if.source result_o,
  wcts_cfg_if.sink      cfg_i
);
  import wcts_pkg::*;

  // Configuration
  logic [10:0] screen_height_q, screen_height_d;
  logic [3:0]  texture_count_q, texture_count_d;

  always_comb begin
    screen_height_d = screen_height_q;
    texture_count_d = texture_count_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SCREEN_HEIGHT: screen_height_d = cfg_i.data;
        CFG_TEXTURE_COUNT: texture_count_d = cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= SCREEN_HEIGHT_RST;
      texture_count_q <= TEXTURE_COUNT_RST;
    end else begin
      screen_height_q <= screen_height_d;
      texture_count_q <= texture_count_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  // Credit count: items accepted and not yet delivered
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign item_i.ready = cnt_q < CNT_W'(FIFO_DEPTH);
  assign in_acc       = item_i.valid && item_i.ready;
  assign out_acc      = result_o.valid && result_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Input stage
  logic [15:0]           lh1;
  logic [4:0]            limit;
  logic [7:0]            cell_m1;
  logic                  tex_ok;
  logic [LADDR_X_W-1:0]  laddr_x;
  logic [LTEX_X_W-1:0]   ltex_x;
  logic [TX_W-1:0]       tx_raw;
  logic signed [NUM_W-1:0] num_d;
  meta_t                 meta_d;

  always_comb begin
    lh1     = (item_i.line_height == '0) ? 16'd1 : item_i.line_height;
    limit   = ({1'b0, texture_count_q} < 5'(NUM_TEXTURES)) ? {1'b0, texture_count_q}
                                                           : 5'(NUM_TEXTURES);
    cell_m1 = item_i.cell_value - 8'd1;
    tex_ok  = (item_i.cell_value != '0) && (9'(cell_m1) < 9'(limit));
    laddr_x = LADDR_X_W'(item_i.load_address);
    ltex_x  = LTEX_X_W'(item_i.load_texture);
    tx_raw  = item_i.wall_fraction[15 -: TX_W];

    num_d = $signed({{(NUM_W-11){1'b0}}, item_i.row, 1'b0})
          - $signed({{(NUM_W-11){1'b0}}, screen_height_q})
          + $signed({{(NUM_W-16){1'b0}}, lh1});

    meta_d.kind      = item_i.kind;
    meta_d.load_ok   = (ltex_x < LTEX_X_W'(NUM_TEXTURES)) &&
                       (laddr_x < LADDR_X_W'(TEX_SIZE));
    meta_d.load_addr = STORE_AW'({ltex_x[TEX_IDX_W-1:0], laddr_x[TEXEL_W-1:0]});
    meta_d.colour    = item_i.load_colour;
    meta_d.column    = item_i.column;
    meta_d.row       = item_i.row;
    meta_d.side      = item_i.hit_side;
    meta_d.tex       = tex_ok ? cell_m1[TEX_IDX_W-1:0] : '0;
    meta_d.tx        = item_i.direction_negative ? ~tx_raw : tx_raw;
  end

  logic                    s0_valid_q;
  logic signed [NUM_W-1:0] s0_num_q;
  logic [15:0]             s0_lh_q;
  meta_t                   s0_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s0_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s0_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_num_q  <= num_d;
    s0_lh_q   <= lh1;
    s0_meta_q <= meta_d;
  end

  // Texel row pipeline
  logic            dv;
  logic [TY_W-1:0] ty;
  meta_t           dm;

  wcts_row_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_valid_q),
    .num_i   (s0_num_q),
    .lh_i    (s0_lh_q),
    .meta_i  (s0_meta_q),
    .valid_o (dv),
    .ty_o    (ty),
    .meta_o  (dm)
  );

  // Store access: a load writes, a pixel reads, same slot
  logic                ram_en, ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [23:0]         texel;

  always_comb begin
    ram_we   = dv && (dm.kind == KIND_LOAD) && dm.load_ok;
    ram_en   = ram_we || (dv && (dm.kind == KIND_SHADE));
    ram_addr = (dm.kind == KIND_LOAD) ? dm.load_addr
                                      : STORE_AW'({dm.tex, ty, dm.tx});
  end

  wcts_texture_ram u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (dm.colour),
    .rdata_o (texel)
  );

  logic  m_valid_q;
  meta_t m_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    m_meta_q <= dm;
  end

  // Shading and result queue
  result_t res_d, res_q;

  always_comb begin
    res_d = '0;
    if (m_meta_q.kind == KIND_SHADE) begin
      res_d.pixel_valid  = 1'b1;
      res_d.pixel_column = m_meta_q.column;
      res_d.pixel_row    = m_meta_q.row;
      res_d.red          = shade_channel(texel[23:16], m_meta_q.side);
      res_d.green        = shade_channel(texel[15:8], m_meta_q.side);
      res_d.blue         = shade_channel(texel[7:0], m_meta_q.side);
    end
  end

  logic fifo_valid;

  wcts_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (m_valid_q),
    .data_i  (res_d),
    .pop_i   (result_o.ready),
    .valid_o (fifo_valid),
    .data_o  (res_q)
  );

  assign result_o.valid        = fifo_valid;
  assign result_o.pixel_valid  = res_q.pixel_valid;
  assign result_o.pixel_column = res_q.pixel_column;
  assign result_o.pixel_row    = res_q.pixel_row;
  assign result_o.red          = res_q.red;
  assign result_o.green        = res_q.green;
  assign result_o.blue         = res_q.blue;

endmodule

[sv/wcts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts_checker
// Port-level checks for the shader core, bound into the shader core module.
// ----------------------------------------------------------------------------
module wcts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        pixel_valid_i,
  input logic [10:0] pixel_column_i,
  input logic [9:0]  pixel_row_i,
  input logic [7:0]  red_i,
  input logic [7:0]  green_i,
  input logic [7:0]  blue_i
);
  import wcts_pkg::*;

  logic                in_acc, out_acc;
  logic [CNT_W:0]      pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // Held result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_valid_i) &&
      $stable(pixel_column_i) && $stable(pixel_row_i) && $stable(red_i) &&
      $stable(green_i) && $stable(blue_i))
    else $error("result beat changed while stalled");

  // No result without an outstanding item
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result with no outstanding item");

  // Input is throttled at the queue size
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> pend_q < (CNT_W + 1)'(FIFO_DEPTH))
    else $error("more items outstanding than the result queue holds");

  // Load acknowledgements carry an all-zero payload
  a_load_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pixel_valid_i |-> pixel_column_i == '0 && pixel_row_i == '0 &&
      red_i == '0 && green_i == '0 && blue_i == '0)
    else $error("load acknowledgement with nonzero payload");

  // Nothing comes out while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind wall_column_texture_shader_core wcts_checker u_wcts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .pixel_valid_i  (result_o.pixel_valid),
  .pixel_column_i (result_o.pixel_column),
  .pixel_row_i    (result_o.pixel_row),
  .red_i          (result_o.red),
  .green_i        (result_o.green),
  .blue_i         (result_o.blue)
);
